>>> hw/rtl/bfcm_pkg.sv
// ----------------------------------------------------------------------------
// bfcm_pkg
// Shared constants, command codes and controller/datapath link types for the
// banked flash command memory.
// ----------------------------------------------------------------------------
package bfcm_pkg;

  localparam int BANK_BYTES_DEF   = 65536;
  localparam int SECTOR_BYTES_DEF = 4096;

  // unlock and command addresses on the bus
  localparam logic [31:0] ADDR_UNLOCK1 = 32'h0E00_5555;
  localparam logic [31:0] ADDR_UNLOCK2 = 32'h0E00_2AAA;
  localparam logic [31:0] ADDR_BASE    = 32'h0E00_0000;

  localparam logic [7:0] UNLOCK1_BYTE = 8'hAA;
  localparam logic [7:0] UNLOCK2_BYTE = 8'h55;
  localparam logic [7:0] ERASED_BYTE  = 8'hFF;

  // command bytes
  localparam logic [7:0] CMD_ID_ON        = 8'h90;
  localparam logic [7:0] CMD_ID_OFF       = 8'hF0;
  localparam logic [7:0] CMD_ERASE_ARM    = 8'h80;
  localparam logic [7:0] CMD_CHIP_ERASE   = 8'h10;
  localparam logic [7:0] CMD_SECTOR_ERASE = 8'h30;
  localparam logic [7:0] CMD_PROGRAM      = 8'hA0;
  localparam logic [7:0] CMD_BANK_SELECT  = 8'hB0;

  // chip ID bytes, offset 0 then offset 1
  localparam logic [7:0] ID1_MFR  = 8'hBF;
  localparam logic [7:0] ID1_DEV  = 8'hD4;
  localparam logic [7:0] ID2_MFR  = 8'hC2;
  localparam logic [7:0] ID2_DEV  = 8'h09;

  // unlock phases
  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_ONE  = 2'd1;
  localparam logic [1:0] PHASE_TWO  = 2'd2;

  // access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic issue;      // accept the input beat this cycle
    logic load_out;   // load the result into the output register
    logic sweep_run;  // write one erased byte and step the sweep
  } bfcm_cmd_t;

  typedef struct packed {
    logic erase_pend; // last accepted beat started an erase
    logic sweep_last; // sweep is at its final byte
  } bfcm_status_t;

endpackage

>>> hw/rtl/bfcm_in_if.sv
// ----------------------------------------------------------------------------
// bfcm_in_if
// Bus access channel: valid/ready handshake carrying one access per beat.
// ----------------------------------------------------------------------------
interface bfcm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] bus_address;
  logic [7:0]  wdata;

  modport source (output valid, output func, output bus_address, output wdata,
                  input ready);
  modport sink (input valid, input func, input bus_address, input wdata,
                output ready);
endinterface

>>> hw/rtl/bfcm_out_if.sv
// ----------------------------------------------------------------------------
// bfcm_out_if
// Result channel: valid/ready handshake carrying one read byte per beat.
// ----------------------------------------------------------------------------
interface bfcm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;

  modport source (output valid, output read_byte, input ready);
  modport sink (input valid, input read_byte, output ready);
endinterface

>>> hw/rtl/bfcm_ctrl.sv
// ----------------------------------------------------------------------------
// bfcm_ctrl
// Controller: clearing pass, beat acceptance, result hand-off and erase sweeps.
// ----------------------------------------------------------------------------
module bfcm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  input  bfcm_pkg::bfcm_status_t status,
  output bfcm_pkg::bfcm_cmd_t  cmd
);
  import bfcm_pkg::*;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RESP, ST_ERASE} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.issue     = (state_r == ST_IDLE) && in_valid;
    cmd.load_out  = (state_r == ST_RESP) && slot_free;
    cmd.sweep_run = (state_r == ST_CLEAR) || (state_r == ST_ERASE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (status.sweep_last) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) state_r <= ST_RESP;
        end
        ST_RESP: begin
          if (slot_free) state_r <= status.erase_pend ? ST_ERASE : ST_IDLE;
        end
        ST_ERASE: begin
          if (status.sweep_last) state_r <= ST_IDLE;
        end
        default: state_r <= ST_CLEAR;
      endcase
    end
  end

endmodule

>>> hw/rtl/bfcm_datapath.sv
// ----------------------------------------------------------------------------
// bfcm_datapath
// Datapath: command decoder, chip state, cell array and erase sweep counter.
// ----------------------------------------------------------------------------
module bfcm_datapath #(
  parameter int BANK_BYTES   = bfcm_pkg::BANK_BYTES_DEF,
  parameter int SECTOR_BYTES = bfcm_pkg::SECTOR_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  in_func,
  input  logic [31:0]           in_bus_address,
  input  logic [7:0]            in_wdata,
  input  bfcm_pkg::bfcm_cmd_t   cmd,
  output bfcm_pkg::bfcm_status_t status,
  output logic [7:0]            out_read_byte
);
  import bfcm_pkg::*;

  localparam int OW    = $clog2(BANK_BYTES);
  localparam int AW    = OW + 1;
  localparam int DEPTH = 2 * BANK_BYTES;
  localparam logic [31:0] OffsMask   = 32'(BANK_BYTES - 1);
  localparam logic [31:0] SectorMask = OffsMask & ~32'(SECTOR_BYTES - 1);
  localparam logic [AW-1:0] SectLow  = AW'(SECTOR_BYTES - 1);
  localparam logic [AW-1:0] AllOnes  = {AW{1'b1}};

  logic [7:0] mem [DEPTH];

  // chip state
  logic        two_bank_r;
  logic [1:0]  phase_r;
  logic        id_mode_r;
  logic        erase_armed_r;
  logic        program_armed_r;
  logic        bank_armed_r;
  logic        bank_r;

  // beat context held for the response
  logic        func_r;
  logic        id_hit_r;
  logic [7:0]  id_byte_r;
  logic [7:0]  rdata_r;
  logic [7:0]  out_byte_r;
  logic        erase_pend_r;

  // sweep
  logic [AW-1:0] sweep_addr_r;
  logic [AW-1:0] sweep_mask_r;

  logic [OW-1:0] offs;
  logic [AW-1:0] cell_addr;
  logic [AW-1:0] sector_base;
  logic          is_u1, is_u2, sect_match;
  logic          id_hit;
  logic [7:0]    id_byte;
  logic          wr_issue;
  logic          chip_erase, sect_erase;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  assign offs        = in_bus_address[OW-1:0];
  assign cell_addr   = {bank_r, offs};
  assign sector_base = cell_addr & ~SectLow;
  assign is_u1       = (in_bus_address == ADDR_UNLOCK1);
  assign is_u2       = (in_bus_address == ADDR_UNLOCK2);
  assign sect_match  = ((in_bus_address & ~SectorMask) == ADDR_BASE);
  assign id_hit      = id_mode_r && (offs[OW-1:1] == '0);
  assign id_byte     = two_bank_r ? (offs[0] ? ID2_DEV : ID2_MFR)
                                  : (offs[0] ? ID1_DEV : ID1_MFR);
  assign wr_issue    = cmd.issue && (in_func == FUNC_WRITE);

  // erase triggers, same priority as the write decoder below
  always_comb begin
    chip_erase = 1'b0;
    sect_erase = 1'b0;
    if (!program_armed_r && !(is_u1 && in_wdata == UNLOCK1_BYTE) &&
        !(is_u2 && in_wdata == UNLOCK2_BYTE && phase_r == PHASE_ONE)) begin
      if (is_u1 && phase_r == PHASE_TWO) begin
        chip_erase = (in_wdata == CMD_CHIP_ERASE) && erase_armed_r;
      end else begin
        sect_erase = erase_armed_r && (in_wdata == CMD_SECTOR_ERASE) &&
                     sect_match && (phase_r == PHASE_TWO);
      end
    end
  end

  assign mem_we    = cmd.sweep_run || (wr_issue && program_armed_r);
  assign mem_waddr = cmd.sweep_run ? sweep_addr_r : cell_addr;
  assign mem_wdata = cmd.sweep_run ? ERASED_BYTE : in_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.issue && in_func == FUNC_READ) rdata_r <= mem[cell_addr];
  end

  // response context and output register
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      func_r    <= in_func;
      id_hit_r  <= id_hit;
      id_byte_r <= id_byte;
    end
    if (cmd.load_out) begin
      if (func_r == FUNC_WRITE) out_byte_r <= 8'h00;
      else if (id_hit_r)        out_byte_r <= id_byte_r;
      else                      out_byte_r <= rdata_r;
    end
  end

  // chip state and sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      two_bank_r      <= 1'b0;
      phase_r         <= PHASE_IDLE;
      id_mode_r       <= 1'b0;
      erase_armed_r   <= 1'b0;
      program_armed_r <= 1'b0;
      bank_armed_r    <= 1'b0;
      bank_r          <= 1'b0;
      erase_pend_r    <= 1'b0;
      sweep_addr_r    <= '0;
      sweep_mask_r    <= AllOnes;
    end else begin
      if (cfg_wr_en) two_bank_r <= cfg_wr_data;
      if (cmd.sweep_run) sweep_addr_r <= sweep_addr_r + AW'(1);
      if (cmd.issue) erase_pend_r <= wr_issue && (chip_erase || sect_erase);
      if (wr_issue) begin
        if (chip_erase) begin
          sweep_addr_r <= '0;
          sweep_mask_r <= AllOnes;
        end else if (sect_erase) begin
          sweep_addr_r <= sector_base;
          sweep_mask_r <= SectLow;
        end
        priority if (program_armed_r) begin
          program_armed_r <= 1'b0;
        end else if (is_u1 && in_wdata == UNLOCK1_BYTE) begin
          phase_r <= PHASE_ONE;
        end else if (is_u2 && in_wdata == UNLOCK2_BYTE && phase_r == PHASE_ONE) begin
          phase_r <= PHASE_TWO;
        end else if (is_u1 && phase_r == PHASE_TWO) begin
          phase_r <= PHASE_IDLE;
          unique case (in_wdata)
            CMD_ID_ON:      id_mode_r <= 1'b1;
            CMD_ID_OFF:     id_mode_r <= 1'b0;
            CMD_ERASE_ARM:  erase_armed_r <= 1'b1;
            CMD_CHIP_ERASE: begin
              if (erase_armed_r) erase_armed_r <= 1'b0;
            end
            CMD_PROGRAM:    program_armed_r <= 1'b1;
            CMD_BANK_SELECT: begin
              if (two_bank_r) bank_armed_r <= 1'b1;
            end
            default: ;
          endcase
        end else if (sect_erase) begin
          erase_armed_r <= 1'b0;
          phase_r       <= PHASE_IDLE;
        end else if (bank_armed_r && in_bus_address == ADDR_BASE) begin
          bank_r       <= in_wdata[0];
          bank_armed_r <= 1'b0;
        end else begin
          phase_r <= phase_r;
        end
      end
    end
  end

  assign status.erase_pend = erase_pend_r;
  assign status.sweep_last = ((sweep_addr_r & sweep_mask_r) == sweep_mask_r);
  assign out_read_byte     = out_byte_r;

endmodule

>>> hw/rtl/banked_flash_command_memory_top.sv
// An accepted beat has its result loaded into the output register in ST_RESP, which waits
//   while an earlier result is stalled; only one access is in flight, so a new beat is taken
//   only after that load (read issue, then result load).
// Chip erase sweeps 2*BANK_BYTES bytes, sector erase SECTOR_BYTES bytes (one byte a cycle).
// Reset: synchronous, active low; a clearing pass over 2*BANK_BYTES bytes (131072 by default)
//   fills the array with 0xFF while in_ch.ready stays low. cfg writes are taken throughout.
// ----------------------------------------------------------------------------
// banked_flash_command_memory_top
// Byte-wide two-bank flash save chip with unlock/command decoding, chip ID
// mode, byte program, chip and sector erase and bank select.
// ----------------------------------------------------------------------------
module banked_flash_command_memory_top #(
  parameter int BANK_BYTES   = bfcm_pkg::BANK_BYTES_DEF,
  parameter int SECTOR_BYTES = bfcm_pkg::SECTOR_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  bfcm_in_if.sink    in_ch,
  bfcm_out_if.source out_ch
);
  import bfcm_pkg::*;

  // command and status link between controller and datapath
  bfcm_cmd_t    cmd;
  bfcm_status_t status;

  // Controller: owns the handshakes. It holds off input beats during the
  // clearing pass and erase sweeps, and keeps only one beat in flight.
  bfcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: decodes the unlock sequence and commands on the accepted beat,
  // reads or programs the cell array, and walks the array for erases.
  bfcm_datapath #(
    .BANK_BYTES   (BANK_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_func        (in_ch.func),
    .in_bus_address (in_ch.bus_address),
    .in_wdata       (in_ch.wdata),
    .cmd            (cmd),
    .status         (status),
    .out_read_byte  (out_ch.read_byte)
  );

endmodule

>>> hw/rtl/bfcm_checker.sv
// ----------------------------------------------------------------------------
// bfcm_checker
// Port-level checks on the top level: result channel hold rules, reset
// behaviour and one access in flight.
// ----------------------------------------------------------------------------
module bfcm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_byte
);

  // a stalled result beat stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its byte
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_read_byte))
    else $error("result byte changed while stalled");

  // reset starts the clearing pass: nothing accepted, nothing offered
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("channel active straight after reset");

  // one access in flight: no input beat in the cycle after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input beat accepted while one is in flight");

endmodule

bind banked_flash_command_memory_top bfcm_checker u_bfcm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_read_byte (out_ch.read_byte)
);
